[rtl/tsf_pkg.sv]
// Shared types, constants and helper functions for the telemetry sentence framer.
package tsf_pkg;

    localparam int CHAR_W  = 8;
    localparam int FRAME_W = 11;
    localparam int LEN_W   = 4;
    localparam int CRC_W   = 16;
    localparam int SKIP_W  = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;
    localparam int SFX_IDX_W  = 3;

    localparam logic [CRC_W-1:0]  CRC_INIT = 16'hFFFF;
    localparam logic [CRC_W-1:0]  CRC_POLY = 16'h1021;
    localparam logic [CHAR_W-1:0] CHAR_STAR = 8'h2A;
    localparam logic [CHAR_W-1:0] CHAR_LF   = 8'h0A;

    localparam logic [SKIP_W-1:0] SKIP_RESET = 4'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SKIP_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DATA_BITS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STOP_BITS  = 2'd2;

    // Suffix positions: '*', four hex digits, newline
    localparam logic [SFX_IDX_W-1:0] SFX_STAR = 3'd0;
    localparam logic [SFX_IDX_W-1:0] SFX_HEX3 = 3'd1;
    localparam logic [SFX_IDX_W-1:0] SFX_HEX2 = 3'd2;
    localparam logic [SFX_IDX_W-1:0] SFX_HEX1 = 3'd3;
    localparam logic [SFX_IDX_W-1:0] SFX_HEX0 = 3'd4;
    localparam logic [SFX_IDX_W-1:0] SFX_LF   = 3'd5;

    typedef struct packed {
        logic data8;   // 8 data bits, else 7
        logic stop2;   // 2 stop bits, else 1
    } frame_cfg_t;

    typedef enum logic [1:0] {
        ST_PASS = 2'b01,
        ST_SFX  = 2'b10
    } state_t;

    function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
                                                  input logic [CHAR_W-1:0] b);
        logic [CRC_W-1:0] r;
        r = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (r[CRC_W-1]) begin
                r = {r[CRC_W-2:0], 1'b0} ^ CRC_POLY;
            end else begin
                r = {r[CRC_W-2:0], 1'b0};
            end
        end
        return r;
    endfunction

    function automatic logic [CHAR_W-1:0] hex_digit(input logic [3:0] v);
        logic [CHAR_W-1:0] c;
        if (v < 4'd10) begin
            c = 8'h30 + {4'h0, v};
        end else begin
            c = 8'h37 + {4'h0, v};
        end
        return c;
    endfunction

endpackage

[rtl/tsf_frame_enc.sv]
// Asynchronous line frame builder: start bit, data bits LSB first, stop bits.
module tsf_frame_enc (
    input  logic [tsf_pkg::CHAR_W-1:0]  ch,
    input  tsf_pkg::frame_cfg_t         cfg,
    output logic [tsf_pkg::FRAME_W-1:0] frame_bits,
    output logic [tsf_pkg::LEN_W-1:0]   frame_length
);

    logic [1:0] stops;

    assign stops = cfg.stop2 ? 2'b11 : 2'b01;

    always_comb begin
        if (cfg.data8) begin
            frame_bits   = {stops, ch, 1'b0};
            frame_length = cfg.stop2 ? 4'd11 : 4'd10;
        end else begin
            frame_bits   = {1'b0, stops, ch[6:0], 1'b0};
            frame_length = cfg.stop2 ? 4'd10 : 4'd9;
        end
    end

endmodule

[rtl/telemetry_sentence_framer_core.sv]
// Top level of the telemetry sentence framer: CRC, suffix sequencer and result register.
//
// Usage:
//   Sentence characters arrive on the s_ channel (s_in_char, s_is_last), one per item.
//   Each item gives one framed result on the m_ channel in the cycle after acceptance.
//   An item flagged last gives seven results: the character itself, '*', four
//   uppercase hex digits of the CRC-16-CCITT (init 0xFFFF) and a newline.
//   Throughput: one item per cycle while m_ready is high; after a last item the
//   input is held off while the suffix drains through the single result register.
//   The CRC update and frame packing are combinational logic in front of that register.
//   The cfg_ channel writes skip_count (0), data_bits (1) and stop_bits (2); it is
//   always ready and should be used only while the block is idle.
//   Reset (aresetn low, synchronous) restores the register defaults, clears the
//   CRC to 0xFFFF and empties the result register.
//   When the receiver stalls the result is held and s_ready drops, since the
//   result register is the only storage between the two sides.
module telemetry_sentence_framer_core (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [tsf_pkg::CHAR_W-1:0]      s_in_char,
    input  logic                            s_is_last,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [tsf_pkg::CHAR_W-1:0]      m_out_char,
    output logic [tsf_pkg::FRAME_W-1:0]     m_frame_bits,
    output logic [tsf_pkg::LEN_W-1:0]       m_frame_length,
    output logic                            m_is_checksum,
    output logic                            m_last_of_sentence,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [tsf_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [tsf_pkg::CFG_DATA_W-1:0]  cfg_data
);

    tsf_pkg::state_t                 state_reg, state_next;
    logic [tsf_pkg::SFX_IDX_W-1:0]   sfx_idx_reg, sfx_idx_next;
    logic [tsf_pkg::CRC_W-1:0]       crc_reg, crc_next;
    logic [tsf_pkg::CRC_W-1:0]       sfx_crc_reg, sfx_crc_next;
    logic [tsf_pkg::SKIP_W-1:0]      seen_reg, seen_next;
    logic [tsf_pkg::SKIP_W-1:0]      skip_reg;
    tsf_pkg::frame_cfg_t             fcfg_reg;

    logic                            m_valid_reg, m_valid_next;
    logic [tsf_pkg::CHAR_W-1:0]      char_reg;
    logic [tsf_pkg::FRAME_W-1:0]     bits_reg;
    logic [tsf_pkg::LEN_W-1:0]       len_reg;
    logic                            chk_reg;
    logic                            last_reg;

    logic                            slot_free;
    logic                            load_in;
    logic                            load_sfx;
    logic [tsf_pkg::CRC_W-1:0]       crc_upd;
    logic [tsf_pkg::CHAR_W-1:0]      sfx_char;
    logic [tsf_pkg::CHAR_W-1:0]      enc_char;
    logic [tsf_pkg::FRAME_W-1:0]     enc_bits;
    logic [tsf_pkg::LEN_W-1:0]       enc_len;

    assign cfg_ready = 1'b1;
    assign slot_free = !m_valid_reg || m_ready;
    assign s_ready   = (state_reg == tsf_pkg::ST_PASS) && slot_free;
    assign load_in   = s_valid && s_ready;
    assign load_sfx  = (state_reg == tsf_pkg::ST_SFX) && slot_free;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            skip_reg       <= tsf_pkg::SKIP_RESET;
            fcfg_reg.data8 <= 1'b0;
            fcfg_reg.stop2 <= 1'b1;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                tsf_pkg::CFG_SKIP_COUNT: skip_reg       <= cfg_data;
                tsf_pkg::CFG_DATA_BITS:  fcfg_reg.data8 <= cfg_data[3];
                tsf_pkg::CFG_STOP_BITS:  fcfg_reg.stop2 <= cfg_data[1];
                default: ;
            endcase
        end
    end

    assign crc_upd = tsf_pkg::crc_byte(crc_reg, s_in_char);

    always_comb begin
        case (sfx_idx_reg)
            tsf_pkg::SFX_STAR: sfx_char = tsf_pkg::CHAR_STAR;
            tsf_pkg::SFX_HEX3: sfx_char = tsf_pkg::hex_digit(sfx_crc_reg[15:12]);
            tsf_pkg::SFX_HEX2: sfx_char = tsf_pkg::hex_digit(sfx_crc_reg[11:8]);
            tsf_pkg::SFX_HEX1: sfx_char = tsf_pkg::hex_digit(sfx_crc_reg[7:4]);
            tsf_pkg::SFX_HEX0: sfx_char = tsf_pkg::hex_digit(sfx_crc_reg[3:0]);
            tsf_pkg::SFX_LF:   sfx_char = tsf_pkg::CHAR_LF;
            default:           sfx_char = tsf_pkg::CHAR_LF;
        endcase
    end

    assign enc_char = (state_reg == tsf_pkg::ST_SFX) ? sfx_char : s_in_char;

    tsf_frame_enc u_enc (
        .ch           (enc_char),
        .cfg          (fcfg_reg),
        .frame_bits   (enc_bits),
        .frame_length (enc_len)
    );

    always_comb begin
        state_next   = state_reg;
        sfx_idx_next = sfx_idx_reg;
        crc_next     = crc_reg;
        sfx_crc_next = sfx_crc_reg;
        seen_next    = seen_reg;
        m_valid_next = m_valid_reg && !m_ready;
        if (load_in) begin
            m_valid_next = 1'b1;
            if (seen_reg >= skip_reg) begin
                sfx_crc_next = crc_upd;
                crc_next     = crc_upd;
            end else begin
                sfx_crc_next = crc_reg;
                seen_next    = seen_reg + 1'b1;
            end
            if (s_is_last) begin
                // Latch the final CRC and restart the sentence state
                state_next   = tsf_pkg::ST_SFX;
                sfx_idx_next = tsf_pkg::SFX_STAR;
                crc_next     = tsf_pkg::CRC_INIT;
                seen_next    = '0;
            end
        end else if (load_sfx) begin
            m_valid_next = 1'b1;
            if (sfx_idx_reg == tsf_pkg::SFX_LF) begin
                state_next = tsf_pkg::ST_PASS;
            end else begin
                sfx_idx_next = sfx_idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= tsf_pkg::ST_PASS;
            sfx_idx_reg <= tsf_pkg::SFX_STAR;
            crc_reg     <= tsf_pkg::CRC_INIT;
            seen_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            sfx_idx_reg <= sfx_idx_next;
            crc_reg     <= crc_next;
            seen_reg    <= seen_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Result payload: load on either source, hold otherwise
    always_ff @(posedge aclk) begin
        sfx_crc_reg <= sfx_crc_next;
        if (load_in || load_sfx) begin
            char_reg <= enc_char;
            bits_reg <= enc_bits;
            len_reg  <= enc_len;
            chk_reg  <= load_sfx;
            last_reg <= load_sfx && (sfx_idx_reg == tsf_pkg::SFX_LF);
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_out_char         = char_reg;
    assign m_frame_bits       = bits_reg;
    assign m_frame_length     = len_reg;
    assign m_is_checksum      = chk_reg;
    assign m_last_of_sentence = last_reg;

    a_no_input_in_suffix: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == tsf_pkg::ST_SFX) |-> !s_ready)
        else $error("input accepted during suffix burst");

    a_last_starts_suffix: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_is_last) |=> (state_reg == tsf_pkg::ST_SFX))
        else $error("last item did not start suffix");

    a_last_is_checksum: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_last_of_sentence) |-> m_is_checksum)
        else $error("sentence end outside suffix");

    a_suffix_body_in_sfx: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_is_checksum && !m_last_of_sentence) |-> (state_reg == tsf_pkg::ST_SFX))
        else $error("suffix item shown while sequencer idle");

endmodule

[sim/telemetry_sentence_framer_core_test.sv]
// Self-checking testbench for the telemetry sentence framer core.
module telemetry_sentence_framer_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_DIRECTED      = 22;
    localparam int N_PHASES        = 8;
    localparam int ITEMS_PER_PHASE = 45;
    localparam int CYCLE_LIMIT     = 200000;
    localparam int MAX_REPORTS     = 10;
    localparam int SETTLE_CYCLES   = 4;

    localparam logic [tsf_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    localparam logic [tsf_pkg::CHAR_W-1:0] ASCII_DOLLAR  = 8'h24;
    localparam logic [tsf_pkg::CHAR_W-1:0] ASCII_ZERO    = 8'h30;
    localparam logic [tsf_pkg::CHAR_W-1:0] ASCII_UPPER_A = 8'h41;
    localparam logic [tsf_pkg::CHAR_W-1:0] PRINT_LO      = 8'h20;
    localparam logic [tsf_pkg::CHAR_W-1:0] PRINT_HI      = 8'h7E;

    typedef struct packed {
        logic [tsf_pkg::CHAR_W-1:0]  ch;
        logic [tsf_pkg::FRAME_W-1:0] bits;
        logic [tsf_pkg::LEN_W-1:0]   len;
        logic                        chk;
        logic                        eos;
    } line_frame_t;

    typedef struct packed {
        logic [tsf_pkg::CHAR_W-1:0]  ch;
        logic                        last;
        logic                        typed;
        logic [tsf_pkg::FRAME_W-1:0] bits;
        logic [tsf_pkg::LEN_W-1:0]   len;
    } stim_row_t;

    // Reset framing is 7 data bits and 2 stop bits, so typed frames are 10 bits long
    localparam stim_row_t DIRECTED_ROWS [0:N_DIRECTED-1] = '{
        '{8'h00, 1'b0, 1'b1, 11'h300, 4'd10},
        '{8'hFF, 1'b1, 1'b1, 11'h3FE, 4'd10},
        '{8'h24, 1'b0, 1'b1, 11'h348, 4'd10},
        '{8'h24, 1'b0, 1'b0, 11'h000, 4'd0},
        '{8'h80, 1'b0, 1'b1, 11'h300, 4'd10},
        '{8'h7F, 1'b0, 1'b1, 11'h3FE, 4'd10},
        '{8'h00, 1'b0, 1'b1, 11'h300, 4'd10},
        '{8'h41, 1'b0, 1'b0, 11'h000, 4'd0},
        '{8'h7E, 1'b0, 1'b0, 11'h000, 4'd0},
        '{8'h01, 1'b1, 1'b0, 11'h000, 4'd0},
        '{8'h55, 1'b1, 1'b1, 11'h3AA, 4'd10},
        '{8'hAA, 1'b1, 1'b1, 11'h354, 4'd10},
        '{8'h24, 1'b0, 1'b0, 11'h000, 4'd0},
        '{8'h24, 1'b0, 1'b0, 11'h000, 4'd0},
        '{8'h54, 1'b0, 1'b0, 11'h000, 4'd0},
        '{8'h45, 1'b0, 1'b0, 11'h000, 4'd0},
        '{8'h53, 1'b0, 1'b0, 11'h000, 4'd0},
        '{8'h54, 1'b0, 1'b0, 11'h000, 4'd0},
        '{8'h2C, 1'b0, 1'b0, 11'h000, 4'd0},
        '{8'h31, 1'b0, 1'b0, 11'h000, 4'd0},
        '{8'h32, 1'b0, 1'b0, 11'h000, 4'd0},
        '{8'h33, 1'b1, 1'b0, 11'h000, 4'd0}
    };

    // Explicit settings for the first phases; later phases draw random ones
    localparam logic [3:0] PH_SKIP [0:3] = '{4'd0, 4'd15, 4'd3, 4'd1};
    localparam logic [3:0] PH_DATA [0:3] = '{4'd8, 4'd7, 4'd15, 4'd0};
    localparam logic [1:0] PH_STOP [0:3] = '{2'd1, 2'd2, 2'd0, 2'd3};
    localparam int TX_GAP [0:3] = '{0, 48, 0, 17};
    localparam int RX_GAP [0:3] = '{0, 0, 48, 17};

    logic                               aclk;
    logic                               aresetn   = 1'b0;
    logic                               s_valid   = 1'b0;
    logic                               s_ready;
    logic [tsf_pkg::CHAR_W-1:0]         s_in_char = '0;
    logic                               s_is_last = 1'b0;
    logic                               m_valid;
    logic                               m_ready   = 1'b0;
    logic [tsf_pkg::CHAR_W-1:0]         m_out_char;
    logic [tsf_pkg::FRAME_W-1:0]        m_frame_bits;
    logic [tsf_pkg::LEN_W-1:0]          m_frame_length;
    logic                               m_is_checksum;
    logic                               m_last_of_sentence;
    logic                               cfg_valid = 1'b0;
    logic                               cfg_ready;
    logic [tsf_pkg::CFG_IDX_W-1:0]      cfg_index = '0;
    logic [tsf_pkg::CFG_DATA_W-1:0]     cfg_data  = '0;

    // Predictor state and its copy of the registers
    logic [tsf_pkg::CRC_W-1:0]  crc_acc       = tsf_pkg::CRC_INIT;
    logic [tsf_pkg::SKIP_W-1:0] chars_counted = '0;
    logic [3:0]                 skip_cfg      = tsf_pkg::SKIP_RESET;
    logic [3:0]                 data_bits_cfg = 4'd7;
    logic [1:0]                 stop_bits_cfg = 2'd2;

    line_frame_t pending_frames [$];
    int          mismatches   = 0;
    int          cycle_count  = 0;
    int          tx_gap_pct   = 0;
    int          rx_stall_pct = 0;

    telemetry_sentence_framer_core i_dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_in_char          (s_in_char),
        .s_is_last          (s_is_last),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_out_char         (m_out_char),
        .m_frame_bits       (m_frame_bits),
        .m_frame_length     (m_frame_length),
        .m_is_checksum      (m_is_checksum),
        .m_last_of_sentence (m_last_of_sentence),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    function automatic logic [tsf_pkg::CRC_W-1:0] crc_update(
            input logic [tsf_pkg::CRC_W-1:0] c,
            input logic [tsf_pkg::CHAR_W-1:0] b);
        int  i;
        logic fb;
        for (i = tsf_pkg::CHAR_W - 1; i >= 0; i--) begin
            fb = c[tsf_pkg::CRC_W-1] ^ b[i];
            c  = {c[tsf_pkg::CRC_W-2:0], 1'b0};
            if (fb) begin
                c = c ^ tsf_pkg::CRC_POLY;
            end
        end
        return c;
    endfunction

    function automatic line_frame_t frame_char(input logic [tsf_pkg::CHAR_W-1:0] ch,
                                               input logic chk, input logic eos);
        line_frame_t f;
        int          nd;
        int          ns;
        int          i;
        nd = (data_bits_cfg >= 4'd8) ? 8 : 7;
        ns = (stop_bits_cfg >= 2'd2) ? 2 : 1;
        f.ch   = ch;
        f.bits = '0;
        for (i = 0; i < nd; i++) begin
            f.bits[1+i] = ch[i];
        end
        for (i = 0; i < ns; i++) begin
            f.bits[1+nd+i] = 1'b1;
        end
        f.len = tsf_pkg::LEN_W'(1 + nd + ns);
        f.chk = chk;
        f.eos = eos;
        return f;
    endfunction

    function automatic logic [tsf_pkg::CHAR_W-1:0] hex_char(input logic [3:0] nib);
        return (nib < 4'd10) ? ASCII_ZERO + tsf_pkg::CHAR_W'(nib)
                             : ASCII_UPPER_A + tsf_pkg::CHAR_W'(nib - 4'd10);
    endfunction

    function automatic void predict_char(input logic [tsf_pkg::CHAR_W-1:0] ch,
                                         input logic last, input logic typed,
                                         input logic [tsf_pkg::FRAME_W-1:0] bits,
                                         input logic [tsf_pkg::LEN_W-1:0] len);
        line_frame_t f;
        int          k;
        if (chars_counted >= skip_cfg) begin
            crc_acc = crc_update(crc_acc, ch);
        end else begin
            chars_counted = chars_counted + 1'b1;
        end
        f = frame_char(ch, 1'b0, 1'b0);
        if (typed) begin
            f.bits = bits;
            f.len  = len;
        end
        pending_frames.push_back(f);
        if (last) begin
            pending_frames.push_back(frame_char(tsf_pkg::CHAR_STAR, 1'b1, 1'b0));
            for (k = 3; k >= 0; k--) begin
                pending_frames.push_back(frame_char(hex_char(crc_acc[4*k +: 4]), 1'b1, 1'b0));
            end
            pending_frames.push_back(frame_char(tsf_pkg::CHAR_LF, 1'b1, 1'b1));
            crc_acc       = tsf_pkg::CRC_INIT;
            chars_counted = '0;
        end
    endfunction

    task automatic send_char(input logic [tsf_pkg::CHAR_W-1:0] ch, input logic last,
                             input logic typed, input logic [tsf_pkg::FRAME_W-1:0] bits,
                             input logic [tsf_pkg::LEN_W-1:0] len);
        while ($urandom_range(0, 99) < tx_gap_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_in_char <= ch;
        s_is_last <= last;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        predict_char(ch, last, typed, bits, len);
    endtask

    // Leaves cfg_valid high; the caller drops it after the last write
    task automatic write_reg(input logic [tsf_pkg::CFG_IDX_W-1:0] idx,
                             input logic [tsf_pkg::CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) begin
            @(posedge aclk);
        end
        case (idx)
            tsf_pkg::CFG_SKIP_COUNT: skip_cfg      = val;
            tsf_pkg::CFG_DATA_BITS:  data_bits_cfg = val;
            tsf_pkg::CFG_STOP_BITS:  stop_bits_cfg = val[1:0];
            default: ;
        endcase
    endtask

    task automatic drain;
        s_valid <= 1'b0;
        while (pending_frames.size() != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Result side: check each accepted item, then pick the next ready level
    always @(posedge aclk) begin : result_check
        line_frame_t want;
        line_frame_t got;
        if (aresetn && m_valid && m_ready) begin
            got = '{m_out_char, m_frame_bits, m_frame_length, m_is_checksum,
                    m_last_of_sentence};
            if (pending_frames.size() == 0) begin
                if (mismatches < MAX_REPORTS) begin
                    $display("unexpected item: char %h bits %h len %0d chk %b eos %b",
                             got.ch, got.bits, got.len, got.chk, got.eos);
                end
                mismatches++;
            end else begin
                want = pending_frames.pop_front();
                if (got !== want) begin
                    if (mismatches < MAX_REPORTS) begin
                        $display("mismatch: expected char %h bits %h len %0d chk %b eos %b",
                                 want.ch, want.bits, want.len, want.chk, want.eos);
                        $display("          actual   char %h bits %h len %0d chk %b eos %b",
                                 got.ch, got.bits, got.len, got.chk, got.eos);
                    end
                    mismatches++;
                end
            end
        end
        m_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin : stimulus
        int                         p;
        int                         n;
        int                         sentence_left;
        int                         sentence_pos;
        logic [tsf_pkg::CHAR_W-1:0] ch;
        logic                       last;
        sentence_left = 0;
        sentence_pos  = 0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (n = 0; n < N_DIRECTED; n++) begin
            send_char(DIRECTED_ROWS[n].ch, DIRECTED_ROWS[n].last, DIRECTED_ROWS[n].typed,
                      DIRECTED_ROWS[n].bits, DIRECTED_ROWS[n].len);
        end
        drain();

        // Phases may end mid-sentence, so new settings also land inside a sentence
        for (p = 0; p < N_PHASES; p++) begin
            if (p < 4) begin
                write_reg(tsf_pkg::CFG_SKIP_COUNT, PH_SKIP[p]);
                write_reg(tsf_pkg::CFG_DATA_BITS, PH_DATA[p]);
                write_reg(tsf_pkg::CFG_STOP_BITS, {2'b00, PH_STOP[p]});
            end else begin
                write_reg(tsf_pkg::CFG_SKIP_COUNT, 4'($urandom_range(0, 15)));
                write_reg(tsf_pkg::CFG_DATA_BITS, 4'($urandom_range(0, 15)));
                write_reg(tsf_pkg::CFG_STOP_BITS, 4'($urandom_range(0, 3)));
            end
            if (p == 3) begin
                write_reg(CFG_UNUSED, 4'($urandom_range(0, 15)));
            end
            cfg_valid    <= 1'b0;
            tx_gap_pct   = TX_GAP[p % 4];
            rx_stall_pct = RX_GAP[p % 4];
            for (n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (sentence_left == 0) begin
                    sentence_left = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 24);
                    sentence_pos  = 0;
                end
                if (sentence_pos < 2 && $urandom_range(0, 3) != 0) begin
                    ch = ASCII_DOLLAR;
                end else if ($urandom_range(0, 3) == 0) begin
                    ch = 8'($urandom_range(0, 255));
                end else begin
                    ch = 8'($urandom_range(PRINT_LO, PRINT_HI));
                end
                // cut a sentence short now and then
                last = (sentence_left == 1) || ($urandom_range(0, 39) == 0);
                sentence_left = last ? 0 : sentence_left - 1;
                sentence_pos++;
                send_char(ch, last, 1'b0, '0, '0);
            end
            drain();
        end

        if (mismatches == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

[files.f]
rtl/tsf_pkg.sv
rtl/tsf_frame_enc.sv
rtl/telemetry_sentence_framer_core.sv
sim/telemetry_sentence_framer_core_test.sv
